[rtl/core/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the tap tempo estimator
// Field widths, event and display codes, register indexes, the controller
// state type and the subdivision helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  // field widths
  localparam int KIND_W     = 2;
  localparam int STAMP_W    = 32;
  localparam int TEMPO_W    = 13;
  localparam int SUB_W      = 10;
  localparam int MODE_W     = 5;
  localparam int WINDOW_W   = 24;
  localparam int MIN_W      = 20;
  localparam int TIMEOUT_W  = 26;
  localparam int BPM_W      = 22;
  localparam int OUT_DATA_W = 40;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [CFG_ADDR_W-1:0] CFG_TAP_SOURCE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUB_MODE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_IVL    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT    = 3'd4;

  // register reset values
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 24'd3000000;
  localparam logic [MIN_W-1:0]     MIN_RST     = 20'd10000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 26'd8000000;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_TAP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

  // display codes
  localparam logic [1:0] DISP_TAPPED  = 2'd1;
  localparam logic [1:0] DISP_TIMEOUT = 2'd2;

  // serial divider sizes
  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_CNT_W = 6;

  // arithmetic constants
  localparam logic [STAMP_W-1:0]   LATENCY_US    = 32'd40000;
  localparam logic [DIV_NUM_W-1:0] BPM_NUMERATOR = 34'd15360000000;
  localparam logic [BPM_W-1:0]     BPM_MAX       = 22'd4194303;
  localparam logic [TEMPO_W-1:0]   TEMPO_MAX     = 13'd8191;
  localparam logic [TEMPO_W-1:0]   TEMPO_LIMIT   = 13'd600;
  localparam logic [MODE_W-1:0]    MODE_COUNT    = 5'd25;

  // divisor selects over {1,2,3,4,8}
  localparam logic [2:0] SEL_DIV1 = 3'd0;
  localparam logic [2:0] SEL_DIV2 = 3'd1;
  localparam logic [2:0] SEL_DIV3 = 3'd2;
  localparam logic [2:0] SEL_DIV4 = 3'd3;
  localparam logic [2:0] SEL_DIV8 = 3'd4;

  // reciprocal of 3 in Q11, exact for tempos up to 600
  localparam logic [SUB_W-1:0] RECIP3 = 10'd683;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVT,
    S_TAP,
    S_DIFF,
    S_WIN,
    S_BPM,
    S_SUM,
    S_AVG,
    S_OUT
  } tte_state_t;

  // subdivision results
  typedef struct packed {
    logic [SUB_W-1:0] delay_tempo;
    logic [SUB_W-1:0] lfo_tempo;
    logic             in_range;
  } tte_sub_t;

  // tempo divided by one of the five divisors, falling back to the tempo at zero
  function automatic logic [SUB_W-1:0] sub_tempo(input logic [SUB_W-1:0] t,
                                                  input logic [2:0] sel);
    logic [2*SUB_W-1:0] prod;
    logic [SUB_W-1:0]   v;
    prod = {{SUB_W{1'b0}}, t} * {{SUB_W{1'b0}}, RECIP3};
    case (sel)
      SEL_DIV1: v = t;
      SEL_DIV2: v = t >> 1;
      SEL_DIV3: v = SUB_W'(prod[2*SUB_W-1:11]);
      SEL_DIV4: v = t >> 2;
      SEL_DIV8: v = t >> 3;
      default:  v = t;
    endcase
    if (v == '0) begin
      v = t;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tte_div.sv]
// ----------------------------------------------------------------------------
// tte_div: bit-serial restoring divider
// One quotient bit per cycle; the numerator register shifts out its bits and
// takes in the quotient bits, so it holds the quotient when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_div
  import tte_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic      [DIV_NUM_W-1:0] quo,
  output logic                      done
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_NUM_W-1:0] num_nxt;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_diff;
  logic                 q_bit;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
    rem_nxt  = q_bit ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    num_nxt  = {num_r[DIV_NUM_W-2:0], q_bit};
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

`default_nettype wire

[rtl/core/tte_subdiv.sv]
// ----------------------------------------------------------------------------
// tte_subdiv: delay and modulator tempo subdivision
// Splits the mode into delay and modulator divisor selects and divides the
// tempo when it lies in 1..600.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_subdiv
  import tte_pkg::*;
(
  input  wire logic [TEMPO_W-1:0] tempo,
  input  wire logic [MODE_W-1:0]  mode,
  output tte_sub_t                sub
);

  logic [2:0]        dsel;
  logic [2:0]        lsel;
  logic [MODE_W-1:0] lrem;
  logic              in_rng;

  // mode / 5 and mode % 5, unused modes act as mode zero
  always_comb begin
    if (mode < 5'd5) begin
      dsel = SEL_DIV1;
    end else if (mode < 5'd10) begin
      dsel = SEL_DIV2;
    end else if (mode < 5'd15) begin
      dsel = SEL_DIV3;
    end else if (mode < 5'd20) begin
      dsel = SEL_DIV4;
    end else if (mode < MODE_COUNT) begin
      dsel = SEL_DIV8;
    end else begin
      dsel = SEL_DIV1;
    end
    lrem = mode - MODE_W'({2'b0, dsel} * 5'd5);
    lsel = (mode < MODE_COUNT) ? lrem[2:0] : SEL_DIV1;
  end

  // range check and subdivision
  always_comb begin
    in_rng       = (tempo >= 13'd1) && (tempo <= TEMPO_LIMIT);
    sub.in_range = in_rng;
    if (in_rng) begin
      sub.delay_tempo = sub_tempo(tempo[SUB_W-1:0], dsel);
      sub.lfo_tempo   = sub_tempo(tempo[SUB_W-1:0], lsel);
    end else begin
      sub.delay_tempo = '0;
      sub.lfo_tempo   = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tap_tempo_estimator_unit.sv]
// ----------------------------------------------------------------------------
// tap_tempo_estimator_unit: tap tempo estimator with ring averaging
// Arm, check and unused kinds pass through S_EVT and S_OUT to the output register.
// In a tap the bit-serial divider runs once for the interval, if it passes the
// window and minimum tests, and once for the average; the sum adds one ring
// entry per cycle. One item at a time; a result waits in the output register
// while the next item is taken. Synchronous reset spares the working and payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_estimator_unit
  import tte_pkg::*;
#(
  parameter int RING_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [STAMP_W-1:0]    in_tdata,   // [31:0] timestamp_us
  input  wire logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  // result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [12:0] tempo, [22:13] delay_tempo, [32:23] lfo_tempo,
  // [33] tempo_in_range, [35:34] display_state, [39:36] zero
  output logic      [OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W = BPM_W + IDX_W + 1;
  localparam logic [IDX_W-1:0]     IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [SUM_W-1:0]     AVG_BIAS = SUM_W'(RING_DEPTH * 128);
  localparam logic [DIV_DEN_W-1:0] AVG_DEN  = DIV_DEN_W'(RING_DEPTH * 256);

  // configuration registers
  logic                 tap_source_r;
  logic [MODE_W-1:0]    mode_r;
  logic [WINDOW_W-1:0]  window_r;
  logic [MIN_W-1:0]     min_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  // control and tempo state
  tte_state_t         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [STAMP_W-1:0] t_r, t_nxt;
  logic [STAMP_W-1:0] d_r, d_nxt;
  logic [STAMP_W-1:0] prev_r, prev_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [STAMP_W-1:0] activity_r, activity_nxt;
  logic [1:0]         display_r, display_nxt;
  logic [TEMPO_W-1:0] held_r, held_nxt;
  logic [BPM_W-1:0]   ring_r [RING_DEPTH];
  logic [BPM_W-1:0]   ring_nxt [RING_DEPTH];
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]   sum_add;
  logic [IDX_W-1:0]   idx_adv;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [TEMPO_W-1:0] out_tempo_r;
  logic [1:0]         out_disp_r;
  tte_sub_t           out_sub_r;
  logic               out_load;

  // divider and subdivision
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_done;
  tte_sub_t             sub;

  tte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  tte_subdiv u_subdiv (
    .tempo (held_r),
    .mode  (mode_r),
    .sub   (sub)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_source_r <= 1'b0;
      mode_r       <= '0;
      window_r     <= WINDOW_RST;
      min_r        <= MIN_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TAP_SOURCE: tap_source_r <= cfg_wdata[0];
        CFG_SUB_MODE:   mode_r       <= cfg_wdata[MODE_W-1:0];
        CFG_WINDOW:     window_r     <= cfg_wdata[WINDOW_W-1:0];
        CFG_MIN_IVL:    min_r        <= cfg_wdata[MIN_W-1:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    stamp_nxt     = stamp_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    activity_nxt  = activity_r;
    display_nxt   = display_r;
    held_nxt      = held_r;
    ring_nxt      = ring_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    div_start     = 1'b0;
    div_num       = BPM_NUMERATOR;
    div_den       = d_r[DIV_DEN_W-1:0];
    out_load      = 1'b0;
    in_tready     = (state_r == S_IDLE);
    sum_add       = acc_r + SUM_W'(ring_r[cnt_r]);
    idx_adv       = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          stamp_nxt = in_tdata;
          state_nxt = (in_tuser == KIND_TAP) ? S_TAP : S_EVT;
        end
      end
      // arm, check and unused kinds
      S_EVT: begin
        case (kind_r)
          KIND_ARM: activity_nxt = stamp_r;
          KIND_CHECK: begin
            if ((stamp_r - activity_r) > {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout_r}) begin
              display_nxt = DISP_TIMEOUT;
            end
          end
          default: ;
        endcase
        state_nxt = S_OUT;
      end
      // latency compensated tap time
      S_TAP: begin
        t_nxt     = stamp_r + (tap_source_r ? '0 : LATENCY_US);
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        d_nxt     = t_r - prev_r;
        state_nxt = S_WIN;
      end
      // window test, launch interval division
      S_WIN: begin
        prev_nxt      = t_r;
        activity_nxt  = t_r;
        have_prev_nxt = 1'b1;
        if (tap_source_r) begin
          display_nxt = DISP_TAPPED;
        end
        acc_nxt   = AVG_BIAS;
        cnt_nxt   = '0;
        state_nxt = S_SUM;
        if (have_prev_r && (d_r < {{(STAMP_W-WINDOW_W){1'b0}}, window_r})) begin
          if ((d_r > {{(STAMP_W-MIN_W){1'b0}}, min_r}) && (d_r != '0)) begin
            div_start = 1'b1;
            state_nxt = S_BPM;
          end else begin
            idx_nxt = idx_adv;
          end
        end
      end
      // store saturated bpm
      S_BPM: begin
        if (div_done) begin
          if (div_quo > {{(DIV_NUM_W-BPM_W){1'b0}}, BPM_MAX}) begin
            ring_nxt[idx_r] = BPM_MAX;
          end else begin
            ring_nxt[idx_r] = div_quo[BPM_W-1:0];
          end
          idx_nxt   = idx_adv;
          state_nxt = S_SUM;
        end
      end
      // one ring entry per cycle, then launch the average division
      S_SUM: begin
        acc_nxt = sum_add;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_LAST) begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(sum_add);
          div_den   = AVG_DEN;
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        if (div_done) begin
          if (div_quo > {{(DIV_NUM_W-TEMPO_W){1'b0}}, TEMPO_MAX}) begin
            held_nxt = TEMPO_MAX;
          end else begin
            held_nxt = div_quo[TEMPO_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and tempo state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      activity_r  <= '0;
      display_r   <= '0;
      held_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      activity_r  <= activity_nxt;
      display_r   <= display_nxt;
      held_r      <= held_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      ring_r      <= ring_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    stamp_r <= stamp_nxt;
    t_r     <= t_nxt;
    d_r     <= d_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tempo_r <= held_r;
      out_sub_r   <= sub;
      out_disp_r  <= display_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_disp_r, out_sub_r.in_range, out_sub_r.lfo_tempo,
                       out_sub_r.delay_tempo, out_tempo_r};

endmodule

`default_nettype wire
